// File: design/bpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants for the buddy page allocator: default sizes, request
// codes and status codes.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int LEVELS_DEF     = 11;
  localparam int PAGES_DEF      = 4096;
  localparam int PAGE_ORDER_DEF = 12;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_ADD   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_BIG  = 2'd1;
  localparam logic [1:0] ST_NO_BLOCK = 2'd2;

endpackage

// File: design/buddy_page_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy allocator over a page store with one doubly linked free list per
// level; a small sequencer walks the lists and page memories step by step.
// ----------------------------------------------------------------------------
//  Channel  Ports                                              Direction
//  in       in_valid/in_stall, operation, size, page, end      request in
//  out      out_valid/out_stall, block_page, status            one result out
//
// After reset a clearing pass over all PAGES pages wipes the free bits; in_stall
// stays high meanwhile. An allocation searches upward past empty lists and
// splits the block it finds; a free checks for a double free and then merges
// with free buddies; an oversize request is answered with ST_TOO_BIG. An added
// range is carved into aligned blocks, each merged with its free buddies.
// The page memories, with registered reads, pace these steps.
// A new item is taken while a finished result still waits on out_stall.
// ----------------------------------------------------------------------------
module buddy_page_allocator #(
  parameter int LEVELS     = bpa_pkg::LEVELS_DEF,
  parameter int PAGES      = bpa_pkg::PAGES_DEF,
  parameter int PAGE_ORDER = bpa_pkg::PAGE_ORDER_DEF,
  localparam int SW = PAGE_ORDER + LEVELS,
  localparam int PW = $clog2(PAGES),
  localparam int NW = PW + 1,
  localparam int LW = $clog2(LEVELS),
  localparam int CW = $clog2(LEVELS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    in_operation,
  input  logic [SW-1:0] in_size_bytes,
  input  logic [PW-1:0] in_page_addr,
  input  logic [NW-1:0] in_end_page,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [PW-1:0] out_block_page,
  output logic [1:0]    out_status
);

  localparam logic [NW-1:0] NONE = NW'(PAGES);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SEARCH, S_RM_RD, S_RM_WR, S_SPLIT, S_PUSH1, S_PUSH2,
    S_FR_RD, S_FR_CHK, S_MERGE_CHK, S_MERGE_RD, S_REL_PUSH, S_ADD_STEP, S_FINISH
  } state_t;

  state_t        state_r, state_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [CW-1:0] lv_r, lv_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic [PW-1:0] pg_r, pg_nxt;
  logic [PW-1:0] node_r, node_nxt;
  logic [NW-1:0] start_r, start_nxt;
  logic [NW-1:0] end_r, end_nxt;
  logic [PW-1:0] clr_r, clr_nxt;
  logic [PW-1:0] res_page_r, res_page_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  logic          out_valid_r;
  logic [PW-1:0] out_block_page_r;
  logic [1:0]    out_status_r;
  logic          out_load;
  logic [NW-1:0] head_r [LEVELS];
  logic [NW-1:0] head_nxt [LEVELS];

  // Page store, one write and one registered read per array.
  logic          free_mem  [PAGES];
  logic [LW-1:0] level_mem [PAGES];
  logic [NW-1:0] next_mem  [PAGES];
  logic [NW-1:0] prev_mem  [PAGES];
  logic          rd_free_r;
  logic [LW-1:0] rd_level_r;
  logic [NW-1:0] rd_next_r;
  logic [NW-1:0] rd_prev_r;
  logic [PW-1:0] rd_addr;
  logic          free_we, level_we, next_we, prev_we;
  logic [PW-1:0] free_wa, level_wa, next_wa, prev_wa;
  logic          free_wd;
  logic [LW-1:0] level_wd;
  logic [NW-1:0] next_wd, prev_wd;

  logic [LW-1:0] size_lv, best_lv;
  logic          too_big;
  logic [CW-1:0] plv;
  logic [NW-1:0] nb, up, in_end_clamped;
  logic [PW-1:0] pg_mask;

  bpa_calc #(
    .LEVELS(LEVELS), .PAGES(PAGES), .PAGE_ORDER(PAGE_ORDER)
  ) u_calc (
    .size_bytes(in_size_bytes),
    .start_pg  (start_r),
    .end_pg    (end_r),
    .size_lv   (size_lv),
    .too_big   (too_big),
    .best_lv   (best_lv)
  );

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_block_page = out_block_page_r;
  assign out_status     = out_status_r;

  // Allocation works on the search level, release and range add on the merge level.
  assign plv            = (op_r == bpa_pkg::OP_ALLOC) ? cur_r : lv_r;
  assign nb             = {1'b0, pg_r} ^ (NW'(1) << lv_r);
  assign up             = {1'b0, pg_r} + (NW'(1) << (cur_r - CW'(1)));
  assign pg_mask        = ~((PW'(1) << size_lv) - PW'(1));
  assign in_end_clamped = (in_end_page > NONE) ? NONE : in_end_page;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    lv_nxt         = lv_r;
    cur_nxt        = cur_r;
    pg_nxt         = pg_r;
    node_nxt       = node_r;
    start_nxt      = start_r;
    end_nxt        = end_r;
    clr_nxt        = clr_r;
    res_page_nxt   = res_page_r;
    res_status_nxt = res_status_r;
    head_nxt       = head_r;
    out_load       = 1'b0;
    rd_addr        = node_r;
    free_we  = 1'b0; free_wa  = node_r; free_wd  = 1'b0;
    level_we = 1'b0; level_wa = node_r; level_wd = plv[LW-1:0];
    next_we  = 1'b0; next_wa  = node_r; next_wd  = head_r[plv[LW-1:0]];
    prev_we  = 1'b0; prev_wa  = node_r; prev_wd  = NONE;
    case (state_r)
      S_CLEAR: begin
        free_we = 1'b1;
        free_wa = clr_r;
        clr_nxt = clr_r + PW'(1);
        if (clr_r == PW'(PAGES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_operation;
          res_page_nxt   = '0;
          res_status_nxt = bpa_pkg::ST_OK;
          state_nxt      = S_FINISH;
          case (in_operation)
            bpa_pkg::OP_ALLOC: begin
              if (too_big) begin
                res_status_nxt = bpa_pkg::ST_TOO_BIG;
              end else begin
                lv_nxt    = CW'(size_lv);
                cur_nxt   = CW'(size_lv);
                state_nxt = S_SEARCH;
              end
            end
            bpa_pkg::OP_FREE: begin
              if (too_big) begin
                res_status_nxt = bpa_pkg::ST_TOO_BIG;
              end else begin
                lv_nxt    = CW'(size_lv);
                pg_nxt    = in_page_addr & pg_mask;
                state_nxt = S_FR_RD;
              end
            end
            bpa_pkg::OP_ADD: begin
              start_nxt = {1'b0, in_page_addr};
              end_nxt   = in_end_clamped;
              state_nxt = S_ADD_STEP;
            end
            default: begin
              state_nxt = S_FINISH;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (cur_r >= CW'(LEVELS)) begin
          res_status_nxt = bpa_pkg::ST_NO_BLOCK;
          state_nxt      = S_FINISH;
        end else if (head_r[cur_r[LW-1:0]] == NONE) begin
          cur_nxt = cur_r + CW'(1);
        end else begin
          node_nxt  = head_r[cur_r[LW-1:0]][PW-1:0];
          state_nxt = S_RM_RD;
        end
      end
      S_RM_RD: begin
        state_nxt = S_RM_WR;
      end
      S_RM_WR: begin
        // Unlink node_r from the list of level plv.
        if (rd_prev_r < NONE) begin
          next_we = 1'b1;
          next_wa = rd_prev_r[PW-1:0];
          next_wd = rd_next_r;
        end else begin
          head_nxt[plv[LW-1:0]] = rd_next_r;
        end
        if (rd_next_r < NONE) begin
          prev_we = 1'b1;
          prev_wa = rd_next_r[PW-1:0];
          prev_wd = rd_prev_r;
        end
        if (op_r == bpa_pkg::OP_ALLOC) begin
          pg_nxt    = node_r;
          state_nxt = S_SPLIT;
        end else begin
          free_we = 1'b1;
          if (node_r < pg_r) begin
            pg_nxt = node_r;
          end
          lv_nxt    = lv_r + CW'(1);
          state_nxt = S_MERGE_CHK;
        end
      end
      S_SPLIT: begin
        if (cur_r > lv_r) begin
          cur_nxt = cur_r - CW'(1);
          if (up < NONE) begin
            node_nxt  = up[PW-1:0];
            state_nxt = S_PUSH1;
          end
        end else begin
          free_we      = 1'b1;
          free_wa      = pg_r;
          res_page_nxt = pg_r;
          state_nxt    = S_FINISH;
        end
      end
      S_PUSH1: begin
        level_we  = 1'b1;
        next_we   = 1'b1;
        prev_we   = 1'b1;
        free_we   = 1'b1;
        free_wd   = 1'b1;
        state_nxt = S_PUSH2;
      end
      S_PUSH2: begin
        if (head_r[plv[LW-1:0]] < NONE) begin
          prev_we = 1'b1;
          prev_wa = head_r[plv[LW-1:0]][PW-1:0];
          prev_wd = {1'b0, node_r};
        end
        head_nxt[plv[LW-1:0]] = {1'b0, node_r};
        if (op_r == bpa_pkg::OP_ALLOC) begin
          state_nxt = S_SPLIT;
        end else if (op_r == bpa_pkg::OP_ADD) begin
          state_nxt = S_ADD_STEP;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FR_RD: begin
        rd_addr = pg_r;
        if ({1'b0, pg_r} >= NONE) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_FR_CHK;
        end
      end
      S_FR_CHK: begin
        // A block that is already free is a double free and is ignored.
        state_nxt = rd_free_r ? S_FINISH : S_MERGE_CHK;
      end
      S_MERGE_CHK: begin
        if (lv_r >= CW'(LEVELS - 1) || nb >= NONE) begin
          state_nxt = S_REL_PUSH;
        end else begin
          rd_addr   = nb[PW-1:0];
          node_nxt  = nb[PW-1:0];
          state_nxt = S_MERGE_RD;
        end
      end
      S_MERGE_RD: begin
        if (!rd_free_r || rd_level_r != lv_r[LW-1:0]) begin
          state_nxt = S_REL_PUSH;
        end else begin
          state_nxt = S_RM_RD;
        end
      end
      S_REL_PUSH: begin
        node_nxt  = pg_r;
        state_nxt = S_PUSH1;
      end
      S_ADD_STEP: begin
        if (start_r < end_r) begin
          pg_nxt    = start_r[PW-1:0];
          lv_nxt    = CW'(best_lv);
          start_nxt = start_r + (NW'(1) << best_lv);
          state_nxt = S_MERGE_CHK;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= NONE;
      end
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      head_r   <= head_nxt;
      if (out_load) begin
        out_valid_r      <= 1'b1;
        out_block_page_r <= res_page_r;
        out_status_r     <= res_status_r;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    lv_r         <= lv_nxt;
    cur_r        <= cur_nxt;
    pg_r         <= pg_nxt;
    node_r       <= node_nxt;
    start_r      <= start_nxt;
    end_r        <= end_nxt;
    res_page_r   <= res_page_nxt;
    res_status_r <= res_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (free_we) begin
      free_mem[free_wa] <= free_wd;
    end
    if (level_we) begin
      level_mem[level_wa] <= level_wd;
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    rd_free_r  <= free_mem[rd_addr];
    rd_level_r <= level_mem[rd_addr];
    rd_next_r  <= next_mem[rd_addr];
    rd_prev_r  <= prev_mem[rd_addr];
  end

endmodule

// File: design/bpa_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_calc
// Level arithmetic: rounds a byte size to a block level and finds the
// largest aligned block that fits at the front of a page range.
// ----------------------------------------------------------------------------
module bpa_calc #(
  parameter int LEVELS     = bpa_pkg::LEVELS_DEF,
  parameter int PAGES      = bpa_pkg::PAGES_DEF,
  parameter int PAGE_ORDER = bpa_pkg::PAGE_ORDER_DEF,
  localparam int SW = PAGE_ORDER + LEVELS,
  localparam int PW = $clog2(PAGES),
  localparam int NW = PW + 1,
  localparam int LW = $clog2(LEVELS)
) (
  input  logic [SW-1:0] size_bytes,
  input  logic [NW-1:0] start_pg,
  input  logic [NW-1:0] end_pg,
  output logic [LW-1:0] size_lv,
  output logic          too_big,
  output logic [LW-1:0] best_lv
);

  always_comb begin
    size_lv = LW'(LEVELS - 1);
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if ({1'b0, size_bytes} <= ((SW + 1)'(1) << (PAGE_ORDER + i))) begin
        size_lv = LW'(i);
      end
    end
  end

  assign too_big = size_bytes > (SW'(1) << (SW - 1));

  // Larger levels are tested last so that they win.
  always_comb begin
    best_lv = '0;
    for (int i = 1; i < LEVELS; i++) begin
      if (({1'b0, start_pg} + ((NW + 1)'(1) << i)) <= {1'b0, end_pg} &&
          (start_pg & ((NW'(1) << i) - NW'(1))) == '0) begin
        best_lv = LW'(i);
      end
    end
  end

endmodule
